FILE: hw/rtl/mrbl_pkg.sv
// Package: constants and register indexes for the masked rectangle bitmap load.
`default_nettype none

package mrbl_pkg;

    localparam int unsigned WORD_BYTES = 4;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned PIX_W   = 8;
    localparam int unsigned COORD_W = 16;
    localparam int unsigned DEPTH_W = 2;
    localparam int unsigned LEN_W   = COORD_W + 1;
    localparam int unsigned PART_W  = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned SETTLE_W   = 2;

    localparam logic [PIX_W-1:0] FULL_MASK = 8'hFF;
    localparam logic [PART_W-1:0] PIX_MAX  = 3'd7;
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN    = 3'd0,
        CFG_STRIDE    = 3'd1,
        CFG_DEPTH     = 3'd2,
        CFG_LEFT_X    = 3'd3,
        CFG_RIGHT_X   = 3'd4,
        CFG_FIRST_ROW = 3'd5,
        CFG_END_ROW   = 3'd6
    } cfg_index_t;

endpackage

`default_nettype wire

FILE: hw/rtl/masked_rectangle_bitmap_load.sv
// Top level: masked rectangle bitmap load, one masked byte write per source byte.
//
// Accepts one packed source byte per clock unless settling or backpressure holds the
// input, and returns one masked byte write per byte through the stage-A register and
// then an output register that holds under backpressure while the next byte is taken.
// The rectangle geometry (start address, row pitch, row length in bytes, row count,
// edge mask shifts) is kept in registers derived from the configuration registers;
// after any configuration write the input is held off while the product of first row
// and stride and the start address settle. Only the row base, byte column and row
// count carry from one byte to the next, so unstalled rate is one byte per clock.
`default_nettype none

module masked_rectangle_bitmap_load
    import mrbl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // [7:0] pixel_byte
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [47:0]                m_axis_tdata,   // [31:0] write_addr,
                                                       // [39:32] write_data,
                                                       // [47:40] write_mask
    output logic                       m_axis_tlast,   // row_done
    output logic                       m_axis_tuser    // load_done
);

    logic [ADDR_W-1:0]  origin_reg;
    logic [COORD_W-1:0] stride_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [COORD_W-1:0] left_x_reg;
    logic [COORD_W-1:0] right_x_reg;
    logic [COORD_W-1:0] first_row_reg;
    logic [COORD_W-1:0] end_row_reg;

    logic [SETTLE_W-1:0] settle_reg;

    logic [ADDR_W-1:0]  prod_reg;
    logic [ADDR_W-1:0]  pitch_reg;
    logic [COORD_W-1:0] lbyte_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [COORD_W-1:0] rows_reg;
    logic [PART_W-1:0]  lpart_reg;
    logic [PART_W-1:0]  rpart_reg;
    logic [ADDR_W-1:0]  start_addr_reg;

    logic [ADDR_W-1:0]  row_base_reg;
    logic [COORD_W-1:0] byte_col_reg;
    logic [COORD_W-1:0] row_count_reg;

    logic               a_valid_reg;
    logic [ADDR_W-1:0]  a_base_reg;
    logic [COORD_W-1:0] a_col_reg;
    logic [PIX_W-1:0]   a_data_reg;
    logic [PIX_W-1:0]   a_mask_reg;
    logic               a_row_done_reg;
    logic               a_load_done_reg;

    logic               out_valid_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic [PIX_W-1:0]   out_data_reg;
    logic [PIX_W-1:0]   out_mask_reg;
    logic               out_row_done_reg;
    logic               out_load_done_reg;

    logic               cfg_write;
    logic               in_accept;
    logic               out_load;
    logic               a_load;

    logic [PART_W-1:0]  shift_amt;
    logic [PART_W-1:0]  pix_mask;
    logic [COORD_W-1:0] lbyte_next;
    logic [LEN_W-1:0]   rsum;
    logic [LEN_W-1:0]   rbyte_next;
    logic [LEN_W-1:0]   len_next;
    logic [COORD_W-1:0] rows_next;
    logic [PART_W-1:0]  lpart_next;
    logic [PART_W-1:0]  rpart_next;

    logic               load_start;
    logic [ADDR_W-1:0]  cur_base;
    logic               last_byte;
    logic [COORD_W-1:0] row_count_inc;
    logic               last_row;
    logic [PIX_W-1:0]   lmask;
    logic [PIX_W-1:0]   rmask;
    logic [PIX_W-1:0]   mask_next;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign out_load      = !out_valid_reg || m_axis_tready;
    assign a_load        = !a_valid_reg || out_load;
    assign s_axis_tready = (settle_reg == '0) && a_load;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        shift_amt  = 3'd3 - {1'b0, depth_reg};
        pix_mask   = PIX_MAX >> depth_reg;
        lbyte_next = left_x_reg >> shift_amt;
        rsum       = {1'b0, right_x_reg} + {{(LEN_W-PART_W){1'b0}}, pix_mask};
        rbyte_next = rsum >> shift_amt;
        if (rbyte_next > {1'b0, lbyte_next})
        begin
            len_next = rbyte_next - {1'b0, lbyte_next};
        end
        else
        begin
            len_next = LEN_W'(1);
        end
        if (end_row_reg > first_row_reg)
        begin
            rows_next = end_row_reg - first_row_reg;
        end
        else
        begin
            rows_next = COORD_W'(1);
        end
        lpart_next = (left_x_reg[PART_W-1:0] & pix_mask) << depth_reg;
        rpart_next = (right_x_reg[PART_W-1:0] & pix_mask) << depth_reg;
    end

    always_comb
    begin
        load_start    = (byte_col_reg == '0) && (row_count_reg == '0);
        cur_base      = load_start ? start_addr_reg : row_base_reg;
        last_byte     = ({1'b0, byte_col_reg} + LEN_W'(1)) >= len_reg;
        row_count_inc = row_count_reg + COORD_W'(1);
        last_row      = last_byte && ((row_count_inc >= rows_reg) || (row_count_inc == '0));
        lmask         = FULL_MASK >> lpart_reg;
        rmask         = ~(FULL_MASK >> rpart_reg);
        mask_next     = FULL_MASK;
        if (byte_col_reg == '0)
        begin
            mask_next = mask_next & lmask;
        end
        if (last_byte && (rpart_reg != '0))
        begin
            mask_next = mask_next & rmask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg    <= '0;
            stride_reg    <= COORD_W'(1);
            depth_reg     <= '0;
            left_x_reg    <= '0;
            right_x_reg   <= COORD_W'(8);
            first_row_reg <= '0;
            end_row_reg   <= COORD_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ORIGIN:    origin_reg    <= cfg_data;
                CFG_STRIDE:    stride_reg    <= cfg_data[COORD_W-1:0];
                CFG_DEPTH:     depth_reg     <= cfg_data[DEPTH_W-1:0];
                CFG_LEFT_X:    left_x_reg    <= cfg_data[COORD_W-1:0];
                CFG_RIGHT_X:   right_x_reg   <= cfg_data[COORD_W-1:0];
                CFG_FIRST_ROW: first_row_reg <= cfg_data[COORD_W-1:0];
                CFG_END_ROW:   end_row_reg   <= cfg_data[COORD_W-1:0];
                default:       ;
            endcase
        end
    end

    // Settle derived geometry after reset or a configuration write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= SETTLE_CYCLES;
        end
        else if (cfg_write)
        begin
            settle_reg <= SETTLE_CYCLES;
        end
        else if (settle_reg != '0)
        begin
            settle_reg <= settle_reg - SETTLE_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg       <= ADDR_W'(first_row_reg) * ADDR_W'(stride_reg);
        pitch_reg      <= ADDR_W'(stride_reg) * ADDR_W'(WORD_BYTES);
        lbyte_reg      <= lbyte_next;
        len_reg        <= len_next;
        rows_reg       <= rows_next;
        lpart_reg      <= lpart_next;
        rpart_reg      <= rpart_next;
        start_addr_reg <= origin_reg + prod_reg * ADDR_W'(WORD_BYTES)
                          + {{(ADDR_W-COORD_W){1'b0}}, lbyte_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_base_reg  <= '0;
            byte_col_reg  <= '0;
            row_count_reg <= '0;
        end
        else if (in_accept)
        begin
            if (last_byte)
            begin
                byte_col_reg  <= '0;
                row_base_reg  <= cur_base + pitch_reg;
                row_count_reg <= last_row ? '0 : row_count_inc;
            end
            else
            begin
                row_base_reg <= cur_base;
                byte_col_reg <= byte_col_reg + COORD_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_load)
        begin
            a_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_base_reg      <= cur_base;
            a_col_reg       <= byte_col_reg;
            a_data_reg      <= s_axis_tdata;
            a_mask_reg      <= mask_next;
            a_row_done_reg  <= last_byte;
            a_load_done_reg <= last_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && a_valid_reg)
        begin
            out_addr_reg      <= a_base_reg + {{(ADDR_W-COORD_W){1'b0}}, a_col_reg};
            out_data_reg      <= a_data_reg;
            out_mask_reg      <= a_mask_reg;
            out_row_done_reg  <= a_row_done_reg;
            out_load_done_reg <= a_load_done_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_mask_reg, out_data_reg, out_addr_reg};
    assign m_axis_tlast  = out_row_done_reg;
    assign m_axis_tuser  = out_load_done_reg;

`ifndef NO_ASSERTIONS
    a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !s_axis_tready)
        else $error("input taken while geometry settles");

    a_load_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("load end without row end");

    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && last_row |=> byte_col_reg == '0 && row_count_reg == '0)
        else $error("counters not rearmed after load end");

    a_col_advance: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !last_byte |=> byte_col_reg == $past(byte_col_reg) + COORD_W'(1))
        else $error("byte column did not advance");
`endif

endmodule

`default_nettype wire

FILE: tb/bitmap_write_checker.sv
// Checker: predicts the masked bitmap write for each source byte and compares each result.
`timescale 1ns / 100ps

module bitmap_write_checker
    import mrbl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] pixel_byte
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [47:0]           m_axis_tdata,   // [31:0] write_addr,
                                                  // [39:32] write_data,
                                                  // [47:40] write_mask
    input  logic                  m_axis_tlast,   // row_done
    input  logic                  m_axis_tuser,   // load_done
    output int unsigned           mismatches,
    output int unsigned           outstanding
);

    typedef struct packed {
        logic [31:0] addr;
        logic [7:0]  data;
        logic [7:0]  mask;
        logic        row_done;
        logic        load_done;
    } bitmap_write_t;

    logic [31:0] origin;
    logic [15:0] stride;
    logic [1:0]  depth;
    logic [15:0] left_x;
    logic [15:0] right_x;
    logic [15:0] first_row;
    logic [15:0] end_row;

    logic [31:0] line_base;
    int unsigned col;
    int unsigned rows_done;

    bitmap_write_t expected_writes[$];
    bitmap_write_t oldest;
    int unsigned   errs = 0;

    function automatic bitmap_write_t next_write(input logic [7:0] pixel);
        int unsigned   shift;
        int unsigned   pix_in_byte;
        int unsigned   lpart;
        int unsigned   rpart;
        int unsigned   lbyte;
        int unsigned   rbyte;
        int unsigned   span;
        int unsigned   height;
        bitmap_write_t w;
        shift       = 3 - depth;
        pix_in_byte = 32'(PIX_MAX) >> depth;
        lpart       = (left_x & pix_in_byte) << depth;
        rpart       = (right_x & pix_in_byte) << depth;
        lbyte       = left_x >> shift;
        rbyte       = (right_x + pix_in_byte) >> shift;
        span        = (rbyte > lbyte) ? rbyte - lbyte : 1;
        height      = (end_row > first_row) ? end_row - first_row : 1;
        if (col == 0 && rows_done == 0)
        begin
            line_base = origin + first_row * stride * WORD_BYTES + lbyte;
        end
        w.mask = FULL_MASK;
        if (col == 0)
        begin
            w.mask = w.mask & (FULL_MASK >> lpart);
        end
        w.row_done = (col + 1 >= span);
        if (w.row_done && rpart != 0)
        begin
            w.mask = w.mask & ~(FULL_MASK >> rpart);
        end
        w.addr      = line_base + col;
        w.data      = pixel;
        w.load_done = 1'b0;
        if (w.row_done)
        begin
            col       = 0;
            rows_done = (rows_done + 1) & 32'hFFFF;
            line_base = line_base + stride * WORD_BYTES;
            if (rows_done >= height || rows_done == 0)
            begin
                w.load_done = 1'b1;
                rows_done   = 0;
            end
        end
        else
        begin
            col = (col + 1) & 32'hFFFF;
        end
        return w;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            errs++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin    = 32'd0;
            stride    = 16'd1;
            depth     = 2'd0;
            left_x    = 16'd0;
            right_x   = 16'd8;
            first_row = 16'd0;
            end_row   = 16'd1;
            line_base = 32'd0;
            col       = 0;
            rows_done = 0;
            expected_writes.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ORIGIN:    origin    = cfg_data;
                    CFG_STRIDE:    stride    = cfg_data[15:0];
                    CFG_DEPTH:     depth     = cfg_data[1:0];
                    CFG_LEFT_X:    left_x    = cfg_data[15:0];
                    CFG_RIGHT_X:   right_x   = cfg_data[15:0];
                    CFG_FIRST_ROW: first_row = cfg_data[15:0];
                    CFG_END_ROW:   end_row   = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_writes.size() == 0)
                begin
                    errs++;
                    $display("%0t: unexpected write: expected none, got tdata %h last %b user %b",
                             $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end
                else
                begin
                    oldest = expected_writes.pop_front();
                    check_field("write_addr", oldest.addr, m_axis_tdata[31:0]);
                    check_field("write_data", 32'(oldest.data), 32'(m_axis_tdata[39:32]));
                    check_field("write_mask", 32'(oldest.mask), 32'(m_axis_tdata[47:40]));
                    check_field("row_done", 32'(oldest.row_done), 32'(m_axis_tlast));
                    check_field("load_done", 32'(oldest.load_done), 32'(m_axis_tuser));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_writes.push_back(next_write(s_axis_tdata));
            end
            mismatches  <= errs;
            outstanding <= expected_writes.size();
        end
    end

endmodule

FILE: tb/tb.sv
// Testbench top: drives configuration and source bytes with random idling and gives the verdict.
`timescale 1ns / 100ps

module tb;
    import mrbl_pkg::*;

    localparam int unsigned IDLE_PCT     = 26;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned RANDOM_ITEMS = 1300;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic [7:0]            s_axis_tdata  = '0;
    logic                  m_axis_tready = 1'b0;
    logic                  calm          = 1'b0;
    logic                  hold_off_req  = 1'b0;

    logic        cfg_ready;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned sent = 0;

    always #6 clk = ~clk;

    masked_rectangle_bitmap_load dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    bitmap_write_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin : sink
        int unsigned hold_left;
        logic        hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_off_req != hold_seen)
            begin
                hold_seen = hold_off_req;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    task automatic send_pixel(input logic [7:0] pixel);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pixel;
        do @(posedge clk); while (!s_axis_tready);
        sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_geometry(input logic [31:0] origin, input logic [15:0] stride,
                                input logic [1:0] depth, input logic [15:0] left_col,
                                input logic [15:0] right_col, input logic [15:0] row0,
                                input logic [15:0] row_end);
        write_reg(CFG_ORIGIN, origin);
        write_reg(CFG_STRIDE, {16'($urandom), stride});
        write_reg(CFG_DEPTH, {30'($urandom), depth});
        write_reg(CFG_LEFT_X, {16'($urandom), left_col});
        write_reg(CFG_RIGHT_X, {16'($urandom), right_col});
        write_reg(CFG_FIRST_ROW, {16'($urandom), row0});
        write_reg(CFG_END_ROW, {16'($urandom), row_end});
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : main
        int unsigned phase;
        int unsigned rand_start;
        int unsigned shift;
        int unsigned pix_in_byte;
        int unsigned span;
        int unsigned height;
        int unsigned count;
        int unsigned width;
        logic [1:0]  depth;
        logic [15:0] left_col;
        logic [15:0] right_col;
        logic [15:0] row0;
        logic [15:0] row_end;
        logic        broken;
        logic        hold_phase;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_pixel(8'h00);
        send_pixel(8'hFF);
        drain();

        set_geometry(32'hFFFF_FFFE, 16'hFFFF, 2'd0, 16'd3, 16'd21, 16'd65533, 16'd65535);
        send_pixel(8'hA5);
        send_pixel(8'h5A);
        send_pixel(8'h01);
        send_pixel(8'h80);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        drain();

        set_geometry(32'd0, 16'd1, 2'd3, 16'd65530, 16'd65535, 16'd0, 16'd1);
        repeat (5) send_pixel(8'($urandom));
        drain();

        write_reg(CFG_UNUSED, $urandom);
        set_geometry(32'h1234_5678, 16'd0, 2'd2, 16'd1, 16'd1, 16'd9, 16'd3);
        send_pixel(8'hC3);
        drain();

        set_geometry(32'h0000_0100, 16'd2, 2'd1, 16'd0, 16'd16, 16'd0, 16'd2);
        send_pixel(8'h3C);
        send_pixel(8'hE7);
        drain();
        write_reg(CFG_RIGHT_X, 32'd2);
        cfg_valid <= 1'b0;
        send_pixel(8'h18);
        send_pixel(8'h7E);
        drain();

        rand_start = sent;
        phase = 0;
        while (sent - rand_start < RANDOM_ITEMS)
        begin
            hold_phase = (phase % 12 == 5);
            calm <= (phase >= 8 && phase < 14);
            depth    = 2'($urandom_range(3));
            left_col = 16'($urandom);
            width    = hold_phase ? 64 : $urandom_range(24);
            row0     = 16'($urandom);
            row_end  = row0 + 16'(hold_phase ? 3 : $urandom_range(3));
            right_col = left_col + 16'(width);
            set_geometry($urandom, ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom),
                         depth, left_col, right_col, row0, row_end);

            shift       = 3 - depth;
            pix_in_byte = 7 >> depth;
            span   = ((right_col + pix_in_byte) >> shift) > (left_col >> shift) ?
                     ((right_col + pix_in_byte) >> shift) - (left_col >> shift) : 1;
            height = (row_end > row0) ? row_end - row0 : 1;
            count  = span * height;
            broken = (count > 1) && ($urandom_range(6) == 0);
            if (broken)
            begin
                count = $urandom_range(1, count - 1);
            end

            if (hold_phase)
            begin
                hold_off_req <= ~hold_off_req;
            end
            repeat (count) send_pixel(8'($urandom));
            drain();

            if (broken)
            begin
                write_reg(CFG_RIGHT_X, {16'($urandom), left_col});
                write_reg(CFG_END_ROW, {16'($urandom), row0});
                cfg_valid <= 1'b0;
                send_pixel(8'($urandom));
                drain();
            end
            phase++;
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
